FILE: hdl/nbprt_pkg.sv
`default_nettype none

package nbprt_pkg;

   // Fixed geometry and field widths.
   localparam int PAGES_PER_BLOCK = 32;
   localparam int PAGE_IDX_W      = 5;
   localparam int CFG_W           = 11;
   localparam int CSR_IDX_W       = 1;
   localparam int ADDR_W          = 31;
   localparam int RES_W           = 25;
   localparam int BLOCK_W         = 12;
   localparam int PAGE_NUM_W      = 8;
   localparam int KEY_W           = BLOCK_W + PAGE_IDX_W;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOTAL    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_RESERVED = 1'b1;
   localparam logic [CFG_W-1:0]     TOTAL_RESET      = 11'd1024;
   localparam logic [CFG_W-1:0]     RESERVED_RESET   = 11'd32;

   // Request opcodes.
   localparam logic [1:0] OP_RESERVE_META = 2'd0;
   localparam logic [1:0] OP_MAIN_META    = 2'd1;
   localparam logic [1:0] OP_LOG_TO_PHYS  = 2'd2;
   localparam logic [1:0] OP_PHYS_TO_LOG  = 2'd3;

   typedef struct packed {
      logic [1:0]            opcode;
      logic                  is_bad;
      logic                  is_empty;
      logic [BLOCK_W-1:0]    block_number;
      logic [PAGE_NUM_W-1:0] page_number;
      logic [ADDR_W-1:0]     address;
   } req_payload_type;

   typedef struct packed {
      logic             found;
      logic [RES_W-1:0] result_address;
   } rsp_payload_type;

   // Commands from the sequencer to the datapath, one step each.
   typedef struct packed {
      logic clr_step;
      logic capture;
      logic res_update;
      logic main_map;
      logic main_commit;
      logic div_back;
      logic div_fix;
      logic lookup;
      logic scale;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic slot_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: hdl/nbprt_stream_if.sv
`default_nettype none

interface nbprt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/nbprt_div.sv
`default_nettype none

// Division of a byte address by the page data size or the full page size,
// by a reciprocal multiply, a back multiply and one correction step.
module nbprt_div import nbprt_pkg::*; #(
   parameter int PAGE_DATA_BYTES  = 512,
   parameter int PAGE_TOTAL_BYTES = 528,
   parameter int QUOT_W           = 23,
   parameter int REM_W            = 10
) (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic              sel_total,
   input  wire logic [ADDR_W-1:0] dividend,
   input  wire logic              back,
   input  wire logic              fix,
   output logic      [QUOT_W-1:0] quotient,
   output logic      [REM_W-1:0]  remainder
);

   localparam int DW = $clog2(PAGE_TOTAL_BYTES + 1);
   localparam longint unsigned ONE_SCALED = 64'd1 << ADDR_W;
   localparam logic [QUOT_W-1:0] RECIP_DATA  = QUOT_W'(ONE_SCALED / PAGE_DATA_BYTES);
   localparam logic [QUOT_W-1:0] RECIP_TOTAL = QUOT_W'(ONE_SCALED / PAGE_TOTAL_BYTES);
   localparam logic [DW-1:0]     DIV_DATA    = DW'(PAGE_DATA_BYTES);
   localparam logic [DW-1:0]     DIV_TOTAL   = DW'(PAGE_TOTAL_BYTES);

   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic                     sel_ff, sel_in;
   logic [QUOT_W-1:0]        qest_ff, qest_in;
   logic [ADDR_W-1:0]        qd_ff, qd_in;
   logic [QUOT_W-1:0]        quot_ff, quot_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [QUOT_W-1:0]        recip_sel;
   logic [DW-1:0]            div_sel;
   logic [ADDR_W+QUOT_W-1:0] est_prod;
   logic [QUOT_W+DW-1:0]     back_prod;
   logic [ADDR_W-1:0]        diff;

   always_comb begin
      recip_sel = sel_total ? RECIP_TOTAL : RECIP_DATA;
      div_sel   = sel_ff ? DIV_TOTAL : DIV_DATA;
      est_prod  = dividend * recip_sel;
      back_prod = qest_ff * div_sel;
      diff      = addr_ff - qd_ff;

      addr_in = addr_ff;
      sel_in  = sel_ff;
      qest_in = qest_ff;
      qd_in   = qd_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (load) begin
         addr_in = dividend;
         sel_in  = sel_total;
         qest_in = est_prod[ADDR_W +: QUOT_W];
      end
      if (back) begin
         qd_in = ADDR_W'(back_prod);
      end
      // The estimate is low by at most one.
      if (fix) begin
         if (diff >= ADDR_W'(div_sel)) begin
            quot_in = qest_ff + QUOT_W'(1);
            rem_in  = REM_W'(diff - ADDR_W'(div_sel));
         end else begin
            quot_in = qest_ff;
            rem_in  = REM_W'(diff);
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      sel_ff  <= sel_in;
      qest_ff <= qest_in;
      qd_ff   <= qd_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hdl/nbprt_dp.sv
`default_nettype none

module nbprt_dp import nbprt_pkg::*; #(
   parameter int MAX_BLOCKS       = 1024,
   parameter int PAGE_DATA_BYTES  = 512,
   parameter int PAGE_TOTAL_BYTES = 528
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_cmd_type         cmd,
   output ctrl_status_type           status,
   input  wire req_payload_type      req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int DEPTH  = MAX_BLOCKS * PAGES_PER_BLOCK;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int BLK_W  = ($clog2(MAX_BLOCKS + 1) > CFG_W) ? $clog2(MAX_BLOCKS + 1) : CFG_W;
   localparam int PG_W   = BLK_W + PAGE_IDX_W;
   localparam int QW     = 32 - $clog2(PAGE_DATA_BYTES);
   localparam int RW     = $clog2(PAGE_TOTAL_BYTES);
   localparam int DW     = $clog2(PAGE_TOTAL_BYTES + 1);
   localparam logic [DW-1:0] DATA_BYTES  = DW'(PAGE_DATA_BYTES);
   localparam logic [DW-1:0] TOTAL_BYTES = DW'(PAGE_TOTAL_BYTES);

   // Configuration and derived limits.
   logic [CFG_W-1:0] total_ff, total_in;
   logic [CFG_W-1:0] reserved_ff, reserved_in;
   logic [BLK_W-1:0] eff_total, eff_reserved;
   logic [PG_W-1:0]  main_pages_ff, main_pages_in;
   logic [PG_W-1:0]  reserve_pages_ff, reserve_pages_in;

   // Counters.
   logic [CW-1:0] reserve_seen_ff, reserve_seen_in;
   logic [CW-1:0] main_seen_ff, main_seen_in;
   logic [CW-1:0] next_logical_ff, next_logical_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // Per-item working registers.
   logic [1:0]       op_ff, op_in;
   logic [AW-1:0]    key_ff, key_in;
   logic             res_act_ff, res_act_in;
   logic [AW-1:0]    res_val_ff, res_val_in;
   logic             main_act_ff, main_act_in;
   logic             bad_ff, bad_in;
   logic [AW-1:0]    phys_ff, phys_in;
   logic             keep_ff, keep_in;
   logic             hit_ff, hit_in;
   logic             found_ff, found_in;
   logic [RES_W-1:0] mul_ff, mul_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [RES_W-1:0] rsp_addr_ff, rsp_addr_in;

   // Memories: entries of the two cleared tables carry a valid bit on top.
   logic [AW:0]   reserve_mem [DEPTH];
   logic [AW-1:0] forward_mem [DEPTH];
   logic [AW:0]   reverse_mem [DEPTH];
   logic [AW:0]   res_rd_ff;
   logic [AW-1:0] fwd_rd_ff;
   logic [AW:0]   rev_rd_ff;

   logic          res_we, res_re, fwd_we, rev_we, rev_re;
   logic [AW-1:0] res_waddr, res_raddr, rev_waddr, rev_raddr;
   logic [AW:0]   res_wdata, rev_wdata;

   logic [KEY_W-1:0] key_c;
   logic             key_ok;
   logic [AW-1:0]    phys_c;
   logic [QW-1:0]    quot;
   logic [RW-1:0]    rem;
   logic [AW+DW-1:0] prod_c;

   nbprt_div #(
      .PAGE_DATA_BYTES  (PAGE_DATA_BYTES),
      .PAGE_TOTAL_BYTES (PAGE_TOTAL_BYTES),
      .QUOT_W           (QW),
      .REM_W            (RW)
   ) u_div (
      .clock     (clock),
      .load      (cmd.capture),
      .sel_total (req_payload.opcode == OP_PHYS_TO_LOG),
      .dividend  (req_payload.address),
      .back      (cmd.div_back),
      .fix       (cmd.div_fix),
      .quotient  (quot),
      .remainder (rem)
   );

   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      if (csr_we) begin
         if (csr_index == CSR_IDX_TOTAL) begin
            total_in = csr_wdata;
         end else if (csr_index == CSR_IDX_RESERVED) begin
            reserved_in = csr_wdata;
         end
      end

      // The page limits follow the register values taken at this edge, so an
      // item right after a register write already sees the new geometry.
      eff_total = (BLK_W'(total_in) > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS)
                                                           : BLK_W'(total_in);
      eff_reserved = (BLK_W'(reserved_in) > eff_total) ? eff_total : BLK_W'(reserved_in);
      main_pages_in    = {eff_total - eff_reserved, {PAGE_IDX_W{1'b0}}};
      reserve_pages_in = {eff_reserved, {PAGE_IDX_W{1'b0}}};

      key_c  = {req_payload.block_number, req_payload.page_number[PAGE_IDX_W-1:0]};
      key_ok = ({1'b0, key_c} < (KEY_W + 1)'(DEPTH));

      reserve_seen_in = reserve_seen_ff;
      main_seen_in    = main_seen_ff;
      next_logical_in = next_logical_ff;
      clr_cnt_in      = clr_cnt_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      res_act_in      = res_act_ff;
      res_val_in      = res_val_ff;
      main_act_in     = main_act_ff;
      bad_in          = bad_ff;
      phys_in         = phys_ff;
      keep_in         = keep_ff;
      hit_in          = hit_ff;
      found_in        = found_ff;
      mul_in          = mul_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_addr_in     = rsp_addr_ff;

      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end

      if (cmd.capture) begin
         op_in       = req_payload.opcode;
         key_in      = key_c[AW-1:0];
         bad_in      = req_payload.is_bad | req_payload.is_empty;
         res_val_in  = AW'(main_pages_ff + PG_W'(reserve_seen_ff));
         phys_in     = main_seen_ff[AW-1:0];
         res_act_in  = 1'b0;
         main_act_in = 1'b0;
         if (req_payload.opcode == OP_RESERVE_META &&
             PG_W'(reserve_seen_ff) < reserve_pages_ff) begin
            reserve_seen_in = reserve_seen_ff + CW'(1);
            res_act_in = !req_payload.is_bad && !req_payload.is_empty && key_ok;
         end
         if (req_payload.opcode == OP_MAIN_META &&
             PG_W'(main_seen_ff) < main_pages_ff) begin
            main_seen_in = main_seen_ff + CW'(1);
            main_act_in  = 1'b1;
         end
      end

      // A bad or empty main page takes the reserve page filed under its index.
      phys_c = bad_ff ? res_rd_ff[AW-1:0] : phys_ff;
      if (cmd.main_map) begin
         phys_in = phys_c;
         keep_in = main_act_ff && (!bad_ff || res_rd_ff[AW]) &&
                   (PG_W'(next_logical_ff) < PG_W'(DEPTH));
      end
      if (cmd.main_commit && keep_ff) begin
         next_logical_in = next_logical_ff + CW'(1);
      end

      if (cmd.lookup) begin
         if (op_ff == OP_LOG_TO_PHYS) begin
            hit_in = quot < QW'(next_logical_ff);
         end else begin
            hit_in = (quot < QW'(DEPTH)) && (rem < RW'(PAGE_DATA_BYTES));
         end
      end

      if (op_ff == OP_LOG_TO_PHYS) begin
         prod_c = fwd_rd_ff * TOTAL_BYTES;
      end else begin
         prod_c = rev_rd_ff[AW-1:0] * DATA_BYTES;
      end
      if (cmd.scale) begin
         found_in = hit_ff && (op_ff == OP_LOG_TO_PHYS || rev_rd_ff[AW]);
         mul_in   = RES_W'(prod_c);
      end

      if (cmd.finish) begin
         rsp_found_in = found_ff;
         rsp_addr_in  = found_ff ? mul_ff + RES_W'(rem) : '0;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      res_re    = cmd.capture;
      res_raddr = (req_payload.opcode == OP_RESERVE_META) ? key_c[AW-1:0]
                                                          : main_seen_ff[AW-1:0];
      res_we    = cmd.clr_step || (cmd.res_update && res_act_ff && !res_rd_ff[AW]);
      res_waddr = cmd.clr_step ? clr_cnt_ff : key_ff;
      res_wdata = cmd.clr_step ? '0 : {1'b1, res_val_ff};

      fwd_we    = cmd.main_commit && keep_ff;

      rev_re    = cmd.main_map || cmd.lookup;
      rev_raddr = cmd.main_map ? phys_c : quot[AW-1:0];
      rev_we    = cmd.clr_step || (cmd.main_commit && keep_ff && !rev_rd_ff[AW]);
      rev_waddr = cmd.clr_step ? clr_cnt_ff : phys_ff;
      rev_wdata = cmd.clr_step ? '0 : {1'b1, next_logical_ff[AW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff        <= TOTAL_RESET;
         reserved_ff     <= RESERVED_RESET;
         reserve_seen_ff <= '0;
         main_seen_ff    <= '0;
         next_logical_ff <= '0;
         clr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         total_ff        <= total_in;
         reserved_ff     <= reserved_in;
         reserve_seen_ff <= reserve_seen_in;
         main_seen_ff    <= main_seen_in;
         next_logical_ff <= next_logical_in;
         clr_cnt_ff      <= clr_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_pages_ff    <= main_pages_in;
      reserve_pages_ff <= reserve_pages_in;
      op_ff            <= op_in;
      key_ff           <= key_in;
      res_act_ff       <= res_act_in;
      res_val_ff       <= res_val_in;
      main_act_ff      <= main_act_in;
      bad_ff           <= bad_in;
      phys_ff          <= phys_in;
      keep_ff          <= keep_in;
      hit_ff           <= hit_in;
      found_ff         <= found_in;
      mul_ff           <= mul_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_addr_ff      <= rsp_addr_in;
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         reserve_mem[res_waddr] <= res_wdata;
      end
      if (res_re) begin
         res_rd_ff <= reserve_mem[res_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         forward_mem[next_logical_ff[AW-1:0]] <= phys_ff;
      end
      if (cmd.lookup) begin
         fwd_rd_ff <= forward_mem[quot[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rev_we) begin
         reverse_mem[rev_waddr] <= rev_wdata;
      end
      if (rev_re) begin
         rev_rd_ff <= reverse_mem[rev_raddr];
      end
   end

   assign status.clr_last  = (clr_cnt_ff == AW'(DEPTH - 1));
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_payload.found          = rsp_found_ff;
   assign rsp_payload.result_address = rsp_addr_ff;

`ifndef SYNTH
   // Every mapped logical page comes from a distinct main page.
   a_logical_le_main: assert property (@(posedge clock) disable iff (reset)
      next_logical_ff <= main_seen_ff)
      else $error("more logical pages mapped than main pages seen");
`endif

endmodule

`default_nettype wire

FILE: hdl/nbprt_ctrl.sv
`default_nettype none

module nbprt_ctrl import nbprt_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [1:0]      req_opcode,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   localparam logic [3:0] S_CLEAR       = 4'd0;
   localparam logic [3:0] S_IDLE        = 4'd1;
   localparam logic [3:0] S_RES_WR      = 4'd2;
   localparam logic [3:0] S_MAIN_MAP    = 4'd3;
   localparam logic [3:0] S_MAIN_COMMIT = 4'd4;
   localparam logic [3:0] S_DIV_BACK    = 4'd5;
   localparam logic [3:0] S_DIV_FIX     = 4'd6;
   localparam logic [3:0] S_LOOKUP      = 4'd7;
   localparam logic [3:0] S_SCALE       = 4'd8;
   localparam logic [3:0] S_FINISH      = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_opcode)
                  OP_RESERVE_META: state_in = S_RES_WR;
                  OP_MAIN_META:    state_in = S_MAIN_MAP;
                  OP_LOG_TO_PHYS:  state_in = S_DIV_BACK;
                  OP_PHYS_TO_LOG:  state_in = S_DIV_BACK;
               endcase
            end
         end
         S_RES_WR: begin
            cmd.res_update = 1'b1;
            state_in = S_IDLE;
         end
         S_MAIN_MAP: begin
            cmd.main_map = 1'b1;
            state_in = S_MAIN_COMMIT;
         end
         S_MAIN_COMMIT: begin
            cmd.main_commit = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV_BACK: begin
            cmd.div_back = 1'b1;
            state_in = S_DIV_FIX;
         end
         S_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.slot_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.slot_free)
      else $error("result loaded over an untaken result");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff == S_CLEAR)) |-> $past(status.clr_last))
      else $error("clearing pass left before the last entry");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

FILE: hdl/nand_bad_page_remap_table.sv
`default_nettype none

// Channel    Dir  Payload                                               Transfer
// req_chan   in   opcode, is_bad, is_empty, block_number, page_number,   valid & ready
//                 address
// rsp_chan   out  found, result_address                                  valid & ready
// csr_*      in   csr_index, csr_wdata                                   csr_we
//
// A reserve metadata item runs capture and a reserve write; a main metadata item
// runs capture, a mapping and a commit step; each is led by a table read whose
// result decides a following write. A query runs the reciprocal divider (multiply,
// back multiply, correction), one table read, one scaling multiply and the result
// load. After reset a clearing pass invalidates all MAX_BLOCKS*32 entries (32768 at
// the default) of the reserve and reverse tables; req_chan.ready stays low meanwhile.
// The result sits in an output register; the next item is accepted while it waits,
// and a query only stalls at its last step if the previous result is still untaken.

module nand_bad_page_remap_table import nbprt_pkg::*; #(
   parameter int MAX_BLOCKS       = 1024,
   parameter int PAGE_DATA_BYTES  = 512,
   parameter int PAGE_TOTAL_BYTES = 528
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   nbprt_stream_if.sink              req_chan,
   nbprt_stream_if.source            rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   // The sequencer and the datapath only talk through these two bundles.
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // The sequencer sees the request handshake and the opcode so that it can
   // branch in the same cycle the transfer completes.
   nbprt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.payload.opcode),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Tables, counters, configuration, divider and the result register.
   nbprt_dp #(
      .MAX_BLOCKS       (MAX_BLOCKS),
      .PAGE_DATA_BYTES  (PAGE_DATA_BYTES),
      .PAGE_TOTAL_BYTES (PAGE_TOTAL_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

`default_nettype wire
